// File: src/pbr_pkg.sv
package pbr_pkg;

    localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
    localparam logic [63:0] SEED_RESET = 64'h853c49e6748fea9b;
    localparam logic [63:0] INC_RESET  = 64'hda3e39cb94b95bdb;

    localparam int XS_SHIFT_A = 18;
    localparam int XS_SHIFT_B = 27;
    localparam int ROT_LSB    = 59;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STATE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_INCREMENT = 8'd1;

    // datapath commands, one flag per action
    typedef struct packed {
        logic load_in;   // capture bounds, form span
        logic mul_ll;    // prod <= state_lo * mult_lo
        logic mul_lh;    // prod <= state_lo * mult_hi
        logic mul_hl;    // prod <= state_hi * mult_lo
        logic acc_load;  // acc <= prod
        logic acc_add;   // acc += prod_lo << 32
        logic state_upd; // state <= acc + increment
        logic perm;      // x <= output permutation, start divider
        logic div_step;  // one restoring remainder step
        logic out_load;  // load result into output register
    } t_cmd;

    typedef struct packed {
        logic span_zero;
        logic div_last;
        logic reject;
        logic out_busy;
    } t_stat;

    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] t;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        t   = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
        xs  = t[31:0];
        rot = s[63:ROT_LSB];
        dbl = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

endpackage

// File: src/pcg32_bounded_random.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------
// request  | i_valid / o_ready   | i_range_low, i_range_high
// result   | o_valid / i_ready   | o_random_value
// config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Each draw runs the 64-bit LCG step through states M0 to M4 on one shared
// 32x32 multiplier, then the output permutation, the bit-serial remainder
// and the rejection check. A full-range request skips the remainder and the
// check. A request is accepted in IDLE; a rejected draw starts a new one, and
// the accepted result is then loaded into the output register.
// Reset (synchronous, active low) loads the default seed and increment.
// The result register holds a word until taken; the load waits if full and not taken.
module pcg32_bounded_random
    import pbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_range_low,
    input  logic [31:0]          i_range_high,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_random_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    pbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pbr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

endmodule

// File: src/pbr_ctrl.sv
module pbr_ctrl
    import pbr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M0    = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_M4    = 4'd5;
    localparam logic [3:0] S_PERM  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_M0;
                end
            end
            S_M0: begin
                o_cmd.mul_ll = 1'b1;
                n_state      = S_M1;
            end
            S_M1: begin
                o_cmd.mul_lh   = 1'b1;
                o_cmd.acc_load = 1'b1;
                n_state        = S_M2;
            end
            S_M2: begin
                o_cmd.mul_hl  = 1'b1;
                o_cmd.acc_add = 1'b1;
                n_state       = S_M3;
            end
            S_M3: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_M4;
            end
            S_M4: begin
                o_cmd.state_upd = 1'b1;
                n_state         = S_PERM;
            end
            S_PERM: begin
                o_cmd.perm = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                // full range skips reduction and rejection
                if (i_stat.span_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_stat.div_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_stat.reject ? S_M0 : S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/pbr_dp.sv
module pbr_dp
    import pbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [31:0]          i_range_low,
    input  logic [31:0]          i_range_high,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [31:0]          o_random_value
);

    logic [63:0] r_gen;
    logic [63:0] r_inc;
    logic [31:0] r_lo;
    logic [31:0] r_n;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] r_x;
    logic [31:0] r_dvd;
    logic [31:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    logic [31:0] r_out;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [32:0] trial;
    logic [32:0] n_ext;
    logic [31:0] n_rem;
    logic [31:0] diff;
    logic [31:0] limit;
    logic [31:0] result;

    assign mul_a = i_cmd.mul_hl ? r_gen[63:32] : r_gen[31:0];
    assign mul_b = i_cmd.mul_lh ? PCG_MULT[63:32] : PCG_MULT[31:0];

    assign trial = {r_rem, r_dvd[31]};
    assign n_ext = {1'b0, r_n};
    assign n_rem = (trial >= n_ext) ? 32'(trial - n_ext) : trial[31:0];

    // accept when x - r is at most 2^32 - n
    assign diff   = r_x - r_rem;
    assign limit  = 32'd0 - r_n;
    assign result = r_lo + (o_stat.span_zero ? r_x : r_rem);

    assign o_stat.span_zero = (r_n == 32'd0);
    assign o_stat.div_last  = (r_cnt == 5'd31);
    assign o_stat.reject    = (diff > limit);
    assign o_stat.out_busy  = r_out_valid && !i_ready;

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= SEED_RESET;
            r_inc <= INC_RESET;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_SEED_STATE) begin
                r_gen <= i_cfg_data;
            end else if (i_cmd.state_upd) begin
                r_gen <= r_acc + r_inc;
            end
            if (i_cfg_we && i_cfg_index == CFG_STREAM_INCREMENT) begin
                r_inc <= i_cfg_data | 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lo <= i_range_low;
            r_n  <= i_range_high - i_range_low + 32'd1;
        end
        if (i_cmd.mul_ll || i_cmd.mul_lh || i_cmd.mul_hl) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {r_prod[31:0], 32'd0};
        end
        if (i_cmd.perm) begin
            r_x   <= xsh_rr(r_gen);
            r_dvd <= xsh_rr(r_gen);
            r_rem <= 32'd0;
            r_cnt <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.out_load) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !o_stat.span_zero) |=> (r_rem < r_n))
        else $error("remainder not below span");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_ready))
        else $error("result overwritten while waiting");

    a_accepted_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !o_stat.span_zero) |-> !o_stat.reject)
        else $error("rejected draw delivered");

endmodule

// File: bench/tb_pcg32_bounded_random.sv
module tb_pcg32_bounded_random;
    timeunit 1ns;
    timeprecision 1ps;

    import pbr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 100;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          REPORT_MAX    = 10;
    localparam int          PHASE_WORDS   = 105;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_STREAM_INCREMENT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST   = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [31:0]          i_range_low;
    logic [31:0]          i_range_high;
    logic                 o_valid;
    logic                 i_ready;
    logic [31:0]          o_random_value;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    // predicted generator and the values it owes the output side
    logic [63:0] gen_state;
    logic [63:0] gen_inc;
    logic [31:0] pending_values[$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    bit          tx_gaps     = 1'b0;
    bit          rx_gaps     = 1'b0;
    int          rx_hold_len = 0;

    pcg32_bounded_random DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_values.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // one LCG step, then xorshift and rotate of the new state
    function automatic logic [31:0] pcg_draw();
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [4:0]  lrot;
        gen_state = gen_state * PCG_MULT + gen_inc;
        xs   = 32'(((gen_state >> XS_SHIFT_A) ^ gen_state) >> XS_SHIFT_B);
        rot  = gen_state[63:ROT_LSB];
        lrot = 5'd0 - rot;
        return (xs >> rot) | (xs << lrot);
    endfunction

    function automatic logic [31:0] bounded_pick(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] span;
        logic [31:0] limit;
        logic [31:0] x;
        logic [31:0] r;
        span = hi - lo + 32'd1;
        // zero span means the whole 32-bit range: raw draw, no rejection
        if (span == 32'd0)
            return lo + pcg_draw();
        limit = 32'd0 - span;
        do begin
            x = pcg_draw();
            r = x % span;
        end while (x - r > limit);
        return lo + r;
    endfunction

    // called at a falling edge with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_SEED_STATE:       gen_state = data;
            CFG_STREAM_INCREMENT: gen_inc   = data | 64'd1;
            default: ;  // ignored by the block
        endcase
    endtask

    // called at a falling edge; returns at a falling edge with valid possibly still high
    task automatic send_word(input logic [31:0] lo, input logic [31:0] hi);
        i_valid      <= 1'b1;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (!o_ready);
        pending_values.push_back(bounded_pick(lo, hi));
        @(negedge i_clk);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_values.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // result side: random stall bursts, plus a long hold when requested
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_len != 0) begin
                i_ready <= 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
                i_ready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (o_valid && i_ready) begin
            if (pending_values.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word: random_value %h", o_random_value);
            end else begin
                want = pending_values.pop_front();
                if (o_random_value !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("random_value mismatch: expected %h, got %h",
                                 want, o_random_value);
                end
            end
        end
    end

    // reset seed and increment, bounds at the edges of the field
    task automatic test_reset_bounds();
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'hFFFF_FFFF);  // full range
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_0001, 32'h0000_0000);  // span wraps to zero
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h0000_0005, 32'h0000_0003);  // inverted, span near 2^32
        send_word(32'hFFFF_FFF0, 32'h0000_0005);  // result wraps through zero
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0000_0001);
        send_word(32'h0000_0000, 32'h0000_0002);
        send_word(32'h0000_0000, 32'h7FFF_FFFF);
        send_word(32'h0000_0000, 32'h8000_0000);  // worst case for rejection
        send_word(32'h0000_0000, 32'hFFFF_FFFE);
        send_word(32'd1000, 32'd1009);
        send_word(32'h1234_5678, 32'h1234_5678);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);
        wait_drained();
    endtask

    task automatic test_register_writes();
        // even increment gets bit 0 forced
        write_reg(CFG_SEED_STATE, 64'h0);
        write_reg(CFG_STREAM_INCREMENT, 64'h0);
        repeat (4) send_word($urandom, $urandom);
        send_word(32'h0, 32'hFFFF_FFFF);
        wait_drained();

        write_reg(CFG_SEED_STATE, '1);
        write_reg(CFG_STREAM_INCREMENT, '1);
        repeat (4) send_word($urandom, $urandom);
        send_word(32'h7, 32'h6);
        wait_drained();

        write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
        write_reg(CFG_IDX_LAST, {$urandom, $urandom});
        write_reg(CFG_STREAM_INCREMENT, 64'h8000_0000_0000_0000);
        write_reg(CFG_SEED_STATE, 64'h0000_0000_0000_0001);
        repeat (3) send_word($urandom, $urandom);
        wait_drained();

        // running generator must survive writes to dead indexes
        write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
        write_reg(CFG_IDX_LAST, '1);
        repeat (3) send_word($urandom, $urandom);
        wait_drained();
    endtask

    task automatic test_backpressure();
        logic [31:0] lo;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        repeat (6) begin
            lo = $urandom;
            send_word(lo, lo + $urandom_range(0, 255));
        end
        wait_drained();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (6) send_word($urandom, $urandom);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [31:0] lo;
        logic [31:0] hi;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_reg(CFG_SEED_STATE, {$urandom, $urandom});
            write_reg(CFG_STREAM_INCREMENT, {$urandom, $urandom});
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // stretches with and without gaps; none in the last phase
                if (k % 20 == 0) begin
                    tx_gaps = (phase < 3) && ($urandom_range(0, 3) != 0);
                    rx_gaps = (phase < 3) && ($urandom_range(0, 3) != 0);
                end
                lo = $urandom;
                case ($urandom_range(0, 9))
                    0, 1, 2: hi = lo + $urandom_range(0, 15);
                    3:       hi = lo + 32'h8000_0000 + $urandom_range(0, 4095);
                    4:       hi = lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
                    5:       hi = lo - 32'd1;
                    6:       hi = lo - 32'd1 - $urandom_range(1, 16);
                    7: begin
                        lo = $urandom | 32'd1;
                        hi = $urandom % lo;
                    end
                    default: hi = $urandom;
                endcase
                send_word(lo, hi);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_range_low  = '0;
        i_range_high = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        gen_state    = SEED_RESET;
        gen_inc      = INC_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_bounds();
        test_register_writes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_values.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
src/pbr_pkg.sv
src/pbr_ctrl.sv
src/pbr_dp.sv
src/pcg32_bounded_random.sv
bench/tb_pcg32_bounded_random.sv
